FILE: design/fmt_pkg.sv
// Shared types, codes and constant tables for the FM port timer/capture block.
// Used by fmt_front, fmt_back, fm_port_timer_status_capture and the testbench.
`default_nettype none

package fmt_pkg;

  localparam int unsigned RING_DEPTH_DEF = 4096;
  localparam int unsigned CMD_DEPTH      = 4;
  localparam int unsigned RQ_DEPTH       = 4;
  localparam int unsigned ENTRY_W        = 32;

  // Input function codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_STATUS = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;
  localparam logic [1:0] FUNC_POP    = 2'd3;

  // Classified operations
  localparam logic [2:0] OP_INDEX  = 3'd0;
  localparam logic [2:0] OP_DATA   = 3'd1;
  localparam logic [2:0] OP_STATUS = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_POP    = 3'd4;

  // Bank 0 register indexes with side effects
  localparam logic [7:0] REG_PRESET_ONE = 8'h02;
  localparam logic [7:0] REG_PRESET_TWO = 8'h03;
  localparam logic [7:0] REG_TIMER_CTRL = 8'h04;

  localparam logic [1:0] BANK_HIGH_OFFSET = 2'd2;

  typedef struct packed {
    logic [2:0] op;
    logic       bank;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic        entry_valid;
    logic [14:0] entry_time;
    logic [8:0]  entry_register;
    logic [7:0]  entry_byte;
    logic [31:0] lost_total;
  } res_t;

  typedef logic [255:0][6:0] period_tab_t;

  // Timer period in ms, rounded, for each preset value
  function automatic period_tab_t build_period(input int unsigned scale);
    period_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 7'(((256 - i) * scale + 500) / 1000);
    end
    return tab;
  endfunction

  localparam period_tab_t PER_ONE_TAB = build_period(80);
  localparam period_tab_t PER_TWO_TAB = build_period(320);

endpackage

`default_nettype wire

FILE: design/fm_port_timer_status_capture.sv
// Top level of the FM port timer/status capture block.
// Depends on fmt_pkg, fmt_fifo, fmt_front and fmt_back.
`default_nettype none

// Takes one beat per clock (push while full is low) and executes it on the
// next clock edge at the earliest: a four-entry command queue decouples the
// input from the execution unit, which handles one command per cycle while the
// result queue has room. Every result is registered at execution (a pop reads
// the capture ring through its one registered read port) and lands in a
// four-entry result queue on the following edge. Status reads and pops each
// give one result beat; writes and ticks give none. Sustained rate is one
// beat per cycle as long as results are drained; when the result queue backs
// up, execution stalls and full rises once the command queue fills. The ring
// keeps the newest RING_DEPTH captured data writes; older ones are counted in
// lost_total when a pop finds the ring overrun.
module fm_port_timer_status_capture #(
  parameter int unsigned RING_DEPTH = fmt_pkg::RING_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    in_func,
  input  wire logic [1:0]    in_port_offset,
  input  wire logic [7:0]    in_write_data,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         out_status_byte,
  output logic               out_entry_valid,
  output logic [14:0]        out_entry_time,
  output logic [8:0]         out_entry_register,
  output logic [7:0]         out_entry_byte,
  output logic [31:0]        out_lost_total
);

  localparam int unsigned RQ_CW = $clog2(fmt_pkg::RQ_DEPTH + 1);

  fmt_pkg::cmd_t cmd;
  fmt_pkg::res_t res;
  fmt_pkg::res_t rq_head;
  logic          cmd_valid;
  logic          cmd_take;
  logic          res_valid;
  logic          rq_full;
  logic          room;
  logic [RQ_CW-1:0] rq_level;

  fmt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .func        (in_func),
    .port_offset (in_port_offset),
    .write_data  (in_write_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  // room counts the beat still in the back end's result stage
  assign room = ({1'b0, rq_level} + {{RQ_CW{1'b0}}, res_valid}) <
                (RQ_CW + 1)'(fmt_pkg::RQ_DEPTH);

  fmt_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .room      (room),
    .cmd_take  (cmd_take),
    .res_valid (res_valid),
    .res       (res)
  );

  fmt_fifo #(
    .W     ($bits(fmt_pkg::res_t)),
    .DEPTH (fmt_pkg::RQ_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (pop),
    .rd_data (rq_head),
    .empty   (empty),
    .full    (rq_full),
    .level   (rq_level)
  );

  assign out_status_byte    = rq_head.status_byte;
  assign out_entry_valid    = rq_head.entry_valid;
  assign out_entry_time     = rq_head.entry_time;
  assign out_entry_register = rq_head.entry_register;
  assign out_entry_byte     = rq_head.entry_byte;
  assign out_lost_total     = rq_head.lost_total;

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !rq_full)
    else $error("result beat arrived at a full result queue");
  a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> room)
    else $error("command executed without result queue room");
  a_room_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && cmd_take) |=> !rq_full)
    else $error("result queue filled right after an execution");
`endif

endmodule

`default_nettype wire

FILE: design/fmt_fifo.sv
// Small flop-based FIFO, used for the command queue and the result queue.
// Depends on nothing but its parameters.
`default_nettype none

module fmt_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [W-1:0]                 wr_data,
  input  wire logic                         rd_en,
  output logic      [W-1:0]                 rd_data,
  output logic                              empty,
  output logic                              full,
  output logic      [$clog2(DEPTH+1)-1:0]   level
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == FULL_CNT);
  assign level   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("fifo level did not step up on a lone write");
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("fifo reports full and empty together");
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && do_wr && do_rd) |=> (cnt_r == $past(cnt_r)))
    else $error("fifo level moved on a write plus read");
`endif

endmodule

`default_nettype wire

FILE: design/fmt_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on fmt_pkg and fmt_fifo.
`default_nettype none

module fmt_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    func,
  input  wire logic [1:0]    port_offset,
  input  wire logic [7:0]    write_data,
  output logic               cmd_valid,
  output fmt_pkg::cmd_t      cmd,
  input  wire logic          cmd_take
);

  fmt_pkg::cmd_t cls;
  logic          cmd_empty;
  logic [$clog2(fmt_pkg::CMD_DEPTH+1)-1:0] cmd_level;

  always_comb begin
    cls.bank = (port_offset == fmt_pkg::BANK_HIGH_OFFSET);
    cls.data = write_data;
    unique case (func)
      fmt_pkg::FUNC_WRITE:  cls.op = port_offset[0] ? fmt_pkg::OP_DATA : fmt_pkg::OP_INDEX;
      fmt_pkg::FUNC_STATUS: cls.op = fmt_pkg::OP_STATUS;
      fmt_pkg::FUNC_TICK:   cls.op = fmt_pkg::OP_TICK;
      fmt_pkg::FUNC_POP:    cls.op = fmt_pkg::OP_POP;
    endcase
  end

  fmt_fifo #(
    .W     ($bits(fmt_pkg::cmd_t)),
    .DEPTH (fmt_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (cls),
    .rd_en   (cmd_take),
    .rd_data (cmd),
    .empty   (cmd_empty),
    .full    (full),
    .level   (cmd_level)
  );

  assign cmd_valid = !cmd_empty;

`ifndef SYNTHESIS
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("command taken from an empty queue");
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> (cmd_level != '0))
    else $error("command valid with zero level");
  a_op_legal: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> (cmd.op == fmt_pkg::OP_INDEX || cmd.op == fmt_pkg::OP_DATA ||
                   cmd.op == fmt_pkg::OP_STATUS || cmd.op == fmt_pkg::OP_TICK ||
                   cmd.op == fmt_pkg::OP_POP))
    else $error("queued command carries an unused op code");
`endif

endmodule

`default_nettype wire

FILE: design/fmt_back.sv
// Back end: runs commands against the timer state and the capture ring,
// and forms result beats in the following cycle. Depends on fmt_pkg.
`default_nettype none

module fmt_back #(
  parameter int unsigned RING_DEPTH = fmt_pkg::RING_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire fmt_pkg::cmd_t cmd,
  input  wire logic          room,
  output logic               cmd_take,
  output logic               res_valid,
  output fmt_pkg::res_t      res
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [31:0]   DEPTH_W   = 32'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  // ring storage: time[31:17], register[16:8], data[7:0]
  logic [fmt_pkg::ENTRY_W-1:0] ring [RING_DEPTH];
  logic [fmt_pkg::ENTRY_W-1:0] rdata_r;
  logic [fmt_pkg::ENTRY_W-1:0] wr_entry;

  logic [7:0]  idx_r, idx_nxt;
  logic        bank_r, bank_nxt;
  logic [2:0]  flags_r, flags_nxt;     // {irq, timer1, timer2}
  logic        run1_r, run1_nxt;
  logic        run2_r, run2_nxt;
  logic [1:0]  mask_r, mask_nxt;       // {mask bit 6, mask bit 5}
  logic [7:0]  pre1_r, pre1_nxt;
  logic [7:0]  pre2_r, pre2_nxt;
  logic [31:0] millis_r, millis_nxt;
  logic [31:0] start1_r, start1_nxt;
  logic [31:0] start2_r, start2_nxt;
  logic [31:0] pend_r, pend_nxt;
  logic [31:0] lost_r, lost_nxt;
  logic [AW-1:0] head_slot_r, head_slot_nxt;
  logic [AW-1:0] tail_slot_r, tail_slot_nxt;

  logic        res_v_r, res_v_nxt;
  logic        res_hit_r, res_hit_nxt;
  logic [7:0]  res_status_r, res_status_nxt;
  logic [31:0] res_lost_r, res_lost_nxt;

  logic          take;
  logic          ring_we, ring_re;
  logic [AW-1:0] rd_slot;
  logic [31:0]   el1, el2;
  logic [6:0]    per1, per2;
  logic          hit1, hit2;
  logic          over, avail_nz;

  assign take     = cmd_valid && room;
  assign cmd_take = take;

  // lazy timer check: elapsed ms against the rounded period
  assign el1  = millis_r - start1_r;
  assign el2  = millis_r - start2_r;
  assign per1 = fmt_pkg::PER_ONE_TAB[pre1_r];
  assign per2 = fmt_pkg::PER_TWO_TAB[pre2_r];
  assign hit1 = run1_r && !mask_r[1] && !flags_r[1] &&
                (per1 < 7'd2 || el1[31:7] != '0 || el1[6:0] >= per1);
  assign hit2 = run2_r && !mask_r[0] && !flags_r[0] &&
                (per2 < 7'd2 || el2[31:7] != '0 || el2[6:0] >= per2);

  assign over     = pend_r > DEPTH_W;
  assign avail_nz = pend_r != '0;
  assign rd_slot  = over ? head_slot_r : tail_slot_r;
  assign wr_entry = {millis_r[14:0], bank_r, idx_r, cmd.data};

  always_comb begin
    idx_nxt        = idx_r;
    bank_nxt       = bank_r;
    flags_nxt      = flags_r;
    run1_nxt       = run1_r;
    run2_nxt       = run2_r;
    mask_nxt       = mask_r;
    pre1_nxt       = pre1_r;
    pre2_nxt       = pre2_r;
    millis_nxt     = millis_r;
    start1_nxt     = start1_r;
    start2_nxt     = start2_r;
    pend_nxt       = pend_r;
    lost_nxt       = lost_r;
    head_slot_nxt  = head_slot_r;
    tail_slot_nxt  = tail_slot_r;
    ring_we        = 1'b0;
    ring_re        = 1'b0;
    res_v_nxt      = 1'b0;
    res_hit_nxt    = 1'b0;
    if (take) begin
      unique case (cmd.op)
        fmt_pkg::OP_INDEX: begin
          idx_nxt  = cmd.data;
          bank_nxt = cmd.bank;
        end
        fmt_pkg::OP_DATA: begin
          if (!bank_r && idx_r == fmt_pkg::REG_TIMER_CTRL) begin
            if (cmd.data[7]) begin
              flags_nxt = '0;
              if (run1_r) start1_nxt = millis_r;
              if (run2_r) start2_nxt = millis_r;
            end else begin
              mask_nxt = cmd.data[6:5];
              if (cmd.data[0] && !run1_r) start1_nxt = millis_r;
              if (cmd.data[1] && !run2_r) start2_nxt = millis_r;
              run1_nxt = cmd.data[0];
              run2_nxt = cmd.data[1];
            end
          end else if (!bank_r && idx_r == fmt_pkg::REG_PRESET_ONE) begin
            pre1_nxt = cmd.data;
          end else if (!bank_r && idx_r == fmt_pkg::REG_PRESET_TWO) begin
            pre2_nxt = cmd.data;
          end
          ring_we       = 1'b1;
          head_slot_nxt = (head_slot_r == LAST_SLOT) ? '0 : head_slot_r + 1'b1;
          pend_nxt      = pend_r + 32'd1;
        end
        fmt_pkg::OP_STATUS: begin
          res_v_nxt = 1'b1;
          if (hit1) flags_nxt = flags_nxt | 3'b110;
          if (hit2) flags_nxt = flags_nxt | 3'b101;
        end
        fmt_pkg::OP_TICK: begin
          millis_nxt = millis_r + 32'd1;
        end
        fmt_pkg::OP_POP: begin
          res_v_nxt = 1'b1;
          // overrun: keep only the newest RING_DEPTH entries
          if (over) begin
            lost_nxt = lost_r + (pend_r - DEPTH_W);
          end
          if (avail_nz) begin
            ring_re       = 1'b1;
            res_hit_nxt   = 1'b1;
            tail_slot_nxt = (rd_slot == LAST_SLOT) ? '0 : rd_slot + 1'b1;
            pend_nxt      = (over ? DEPTH_W : pend_r) - 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
    res_status_nxt = {flags_nxt, 5'b0};
    res_lost_nxt   = lost_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      bank_r      <= 1'b0;
      flags_r     <= '0;
      run1_r      <= 1'b0;
      run2_r      <= 1'b0;
      mask_r      <= '0;
      pre1_r      <= '0;
      pre2_r      <= '0;
      millis_r    <= '0;
      start1_r    <= '0;
      start2_r    <= '0;
      pend_r      <= '0;
      lost_r      <= '0;
      head_slot_r <= '0;
      tail_slot_r <= '0;
      res_v_r     <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      bank_r      <= bank_nxt;
      flags_r     <= flags_nxt;
      run1_r      <= run1_nxt;
      run2_r      <= run2_nxt;
      mask_r      <= mask_nxt;
      pre1_r      <= pre1_nxt;
      pre2_r      <= pre2_nxt;
      millis_r    <= millis_nxt;
      start1_r    <= start1_nxt;
      start2_r    <= start2_nxt;
      pend_r      <= pend_nxt;
      lost_r      <= lost_nxt;
      head_slot_r <= head_slot_nxt;
      tail_slot_r <= tail_slot_nxt;
      res_v_r     <= res_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_hit_r    <= res_hit_nxt;
    res_status_r <= res_status_nxt;
    res_lost_r   <= res_lost_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[head_slot_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_re) begin
      rdata_r <= ring[rd_slot];
    end
  end

  assign res_valid          = res_v_r;
  assign res.status_byte    = res_status_r;
  assign res.entry_valid    = res_hit_r;
  assign res.entry_time     = res_hit_r ? rdata_r[31:17] : '0;
  assign res.entry_register = res_hit_r ? rdata_r[16:8] : '0;
  assign res.entry_byte     = res_hit_r ? rdata_r[7:0] : '0;
  assign res.lost_total     = res_lost_r;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && take && (cmd.op == fmt_pkg::OP_STATUS || cmd.op == fmt_pkg::OP_POP))
      |=> res_v_r)
    else $error("result beat missing after status read or pop");
  a_overrun_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && take && cmd.op == fmt_pkg::OP_POP && pend_r > DEPTH_W)
      |=> (pend_r == DEPTH_W - 32'd1 && lost_r == $past(lost_r) + ($past(pend_r) - DEPTH_W)))
    else $error("overrun pop did not clamp pending count");
  a_pop_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && take && cmd.op == fmt_pkg::OP_POP && pend_r != '0) |=> res_hit_r)
    else $error("pop with pending entries returned no entry");
  a_flags_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && take && cmd.op == fmt_pkg::OP_STATUS)
      |=> ((flags_r & $past(flags_r)) == $past(flags_r)))
    else $error("status read cleared a flag");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking bench for fm_port_timer_status_capture: port writes, status reads,
// ticks and ring pops are scored against an in-bench model of the port window.
// Depends on fmt_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RING            = fmt_pkg::RING_DEPTH_DEF;
  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned BURST_WRITES    = 200;
  localparam int unsigned HOLDOFF_CYCLES  = 400;
  localparam int unsigned IDLE_PCT        = 7;
  localparam int unsigned MAX_PRINTS      = 30;

  localparam logic [7:0] FLAG_IRQ   = 8'h80;
  localparam logic [7:0] FLAG_T1    = 8'h40;
  localparam logic [7:0] FLAG_T2    = 8'h20;
  localparam logic [7:0] CTRL_RESET = 8'h80;
  localparam logic [1:0] LOW_INDEX_OFFSET = 2'd0;
  localparam logic [7:0] SCRATCH_REG = 8'h20;

  localparam int unsigned T1_SCALE = 80;
  localparam int unsigned T2_SCALE = 320;

  typedef struct {
    logic [1:0] func;
    logic [1:0] off;
    logic [7:0] data;
    bit         wait_drain;
  } host_op_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_func = '0;
  logic [1:0]  in_port_offset = '0;
  logic [7:0]  in_write_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_status_byte;
  logic        out_entry_valid;
  logic [14:0] out_entry_time;
  logic [8:0]  out_entry_register;
  logic [7:0]  out_entry_byte;
  logic [31:0] out_lost_total;

  fm_port_timer_status_capture #(.RING_DEPTH(RING)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_func            (in_func),
    .in_port_offset     (in_port_offset),
    .in_write_data      (in_write_data),
    .empty              (empty),
    .pop                (pop),
    .out_status_byte    (out_status_byte),
    .out_entry_valid    (out_entry_valid),
    .out_entry_time     (out_entry_time),
    .out_entry_register (out_entry_register),
    .out_entry_byte     (out_entry_byte),
    .out_lost_total     (out_lost_total)
  );

  host_op_t      host_ops[$];
  fmt_pkg::res_t awaited_replies[$];
  host_op_t      cur_op;

  int unsigned ops_queued, ops_sent, replies_seen, entries_popped, mismatches, cycles;
  logic [31:0] lost_seen;
  int unsigned holdoff_left;
  bit          holdoff_done;

  // port window model state
  logic [7:0]  idx_latch, flags, mask_byte, preset_one, preset_two;
  logic        bank_hi, t1_run, t2_run;
  logic [31:0] ms_now, t1_base, t2_base, wr_count, rd_count, dropped;
  int unsigned wr_slot, rd_slot;
  logic [31:0] ring_words [RING];

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic model_reset();
    idx_latch = '0; bank_hi = 1'b0; flags = '0; mask_byte = '0;
    t1_run = 1'b0; t2_run = 1'b0; preset_one = '0; preset_two = '0;
    ms_now = '0; t1_base = '0; t2_base = '0;
    wr_count = '0; rd_count = '0; dropped = '0; wr_slot = 0; rd_slot = 0;
  endtask

  task automatic apply_timer_ctrl(input logic [7:0] v);
    if ((v & CTRL_RESET) != 0) begin
      flags = '0;
      if (t1_run) t1_base = ms_now;
      if (t2_run) t2_base = ms_now;
    end else begin
      mask_byte = v;
      if (v[0] && !t1_run) t1_base = ms_now;
      t1_run = v[0];
      if (v[1] && !t2_run) t2_base = ms_now;
      t2_run = v[1];
    end
  endtask

  task automatic poll_timers();
    logic [31:0] per;
    if (t1_run && (mask_byte & FLAG_T1) == 0 && (flags & FLAG_T1) == 0) begin
      per = ((32'd256 - preset_one) * T1_SCALE + 500) / 1000;
      if (per < 2 || (ms_now - t1_base) >= per) flags = flags | FLAG_IRQ | FLAG_T1;
    end
    if (t2_run && (mask_byte & FLAG_T2) == 0 && (flags & FLAG_T2) == 0) begin
      per = ((32'd256 - preset_two) * T2_SCALE + 500) / 1000;
      if (per < 2 || (ms_now - t2_base) >= per) flags = flags | FLAG_IRQ | FLAG_T2;
    end
  endtask

  // Advance the model by one accepted beat; status reads and pops queue a reply.
  task automatic port_window_step(input host_op_t op);
    fmt_pkg::res_t r;
    logic [8:0]    reg_num;
    logic [31:0]   backlog, w;
    case (op.func)
      fmt_pkg::FUNC_WRITE: begin
        if (!op.off[0]) begin
          idx_latch = op.data;
          bank_hi = (op.off == fmt_pkg::BANK_HIGH_OFFSET);
        end else begin
          if (!bank_hi && idx_latch == fmt_pkg::REG_TIMER_CTRL) apply_timer_ctrl(op.data);
          else if (!bank_hi && idx_latch == fmt_pkg::REG_PRESET_ONE) preset_one = op.data;
          else if (!bank_hi && idx_latch == fmt_pkg::REG_PRESET_TWO) preset_two = op.data;
          reg_num = {bank_hi, idx_latch};
          ring_words[wr_slot] = {ms_now[14:0], reg_num, op.data};
          wr_slot = (wr_slot + 1) % RING;
          wr_count = wr_count + 1;
        end
      end
      fmt_pkg::FUNC_TICK: ms_now = ms_now + 1;
      default: begin
        r = '0;
        if (op.func == fmt_pkg::FUNC_STATUS) begin
          poll_timers();
        end else begin
          backlog = wr_count - rd_count;
          // overrun: keep only the newest RING entries
          if (backlog > RING) begin
            dropped = dropped + (backlog - RING);
            rd_count = wr_count - RING;
            rd_slot = wr_slot;
            backlog = RING;
          end
          if (backlog != 0) begin
            w = ring_words[rd_slot];
            rd_slot = (rd_slot + 1) % RING;
            rd_count = rd_count + 1;
            r.entry_valid = 1'b1;
            r.entry_time = w[31:17];
            r.entry_register = w[16:8];
            r.entry_byte = w[7:0];
          end
        end
        r.status_byte = flags;
        r.lost_total = dropped;
        awaited_replies.push_back(r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_reply();
    fmt_pkg::res_t want;
    replies_seen++;
    if (awaited_replies.size() == 0) begin
      report_mismatch("unexpected reply beat", out_status_byte, 0);
    end else begin
      want = awaited_replies.pop_front();
      if (out_status_byte !== want.status_byte)
        report_mismatch("status_byte", out_status_byte, want.status_byte);
      if (out_entry_valid !== want.entry_valid)
        report_mismatch("entry_valid", out_entry_valid, want.entry_valid);
      if (out_entry_time !== want.entry_time)
        report_mismatch("entry_time", out_entry_time, want.entry_time);
      if (out_entry_register !== want.entry_register)
        report_mismatch("entry_register", out_entry_register, want.entry_register);
      if (out_entry_byte !== want.entry_byte)
        report_mismatch("entry_byte", out_entry_byte, want.entry_byte);
      if (out_lost_total !== want.lost_total)
        report_mismatch("lost_total", out_lost_total, want.lost_total);
      if (want.entry_valid) entries_popped++;
      lost_seen = want.lost_total;
    end
  endtask

  // Driver: after a take, offers the next pending op unless idling or draining.
  always @(posedge clk) begin : drive_ops
    bit idle_now;
    if (!rst_n) begin
      push <= 1'b0;
      model_reset();
    end else begin
      if (push && !full) begin
        port_window_step(cur_op);
        ops_sent++;
      end
      if (!push || !full) begin
        idle_now = (ops_sent >= 300 && ops_sent < 700) ? 1'b0
                 : ($urandom_range(0, 99) < IDLE_PCT);
        if (host_ops.size() != 0 && !idle_now &&
            !(host_ops[0].wait_drain && awaited_replies.size() != 0)) begin
          cur_op = host_ops.pop_front();
          push <= 1'b1;
          in_func <= cur_op.func;
          in_port_offset <= cur_op.off;
          in_write_data <= cur_op.data;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: scores reply beats; one long hold-off lets the block back up.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_reply();
      if (holdoff_left != 0) begin
        holdoff_left--;
        pop <= 1'b0;
      end else if (!holdoff_done && replies_seen >= 100) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= (replies_seen >= 20 && replies_seen < 90) ? 1'b1
             : ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic add_op(input logic [1:0] f, input logic [1:0] o, input logic [7:0] d,
                        input bit drain);
    host_op_t op;
    op.func = f;
    op.off = o;
    op.data = d;
    op.wait_drain = drain;
    host_ops.push_back(op);
    ops_queued++;
  endtask

  // index beat then data beat; data goes to either odd offset
  task automatic add_reg_write(input bit bank, input logic [7:0] idx, input logic [7:0] d);
    add_op(fmt_pkg::FUNC_WRITE, bank ? fmt_pkg::BANK_HIGH_OFFSET : LOW_INDEX_OFFSET, idx,
           1'b0);
    add_op(fmt_pkg::FUNC_WRITE, {1'($urandom), 1'b1}, d, 1'b0);
  endtask

  // biased toward short periods so flags rise within a few ticks
  function automatic logic [7:0] preset_value();
    return $urandom_range(0, 1) ? 8'($urandom_range(230, 255)) : 8'($urandom);
  endfunction

  task automatic queue_random_ops(input int unsigned count);
    int unsigned stop_at, pick;
    stop_at = ops_queued + count;
    while (ops_queued < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        case ($urandom_range(0, 2))
          0: add_reg_write(1'b0, fmt_pkg::REG_PRESET_ONE, preset_value());
          1: add_reg_write(1'b0, fmt_pkg::REG_PRESET_TWO, preset_value());
          default: add_reg_write(1'b0, fmt_pkg::REG_TIMER_CTRL,
                                 ($urandom_range(0, 3) == 0) ? (CTRL_RESET | 8'($urandom))
                                                             : 8'($urandom_range(0, 127)));
        endcase
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 12))
          add_op(fmt_pkg::FUNC_TICK, 2'($urandom), 8'($urandom), 1'b0);
        add_op(fmt_pkg::FUNC_STATUS, 2'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 3))
          add_op(fmt_pkg::FUNC_POP, 2'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 75) begin
        add_op(fmt_pkg::FUNC_STATUS, 2'($urandom), 8'($urandom), 1'b0);
      end else if (pick < 85) begin
        add_reg_write(1'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        add_op(2'($urandom), 2'($urandom), 8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin
    // directed: empty pop, reset status, extreme registers, both banks, timers
    add_op(fmt_pkg::FUNC_POP, 2'd0, 8'h00, 1'b0);
    add_op(fmt_pkg::FUNC_STATUS, 2'd3, 8'hFF, 1'b0);
    add_reg_write(1'b0, 8'hFF, 8'h00);
    add_reg_write(1'b1, 8'h12, 8'hFF);
    add_reg_write(1'b1, fmt_pkg::REG_TIMER_CTRL, 8'h03);   // bank 1: captured only
    add_reg_write(1'b0, fmt_pkg::REG_PRESET_ONE, 8'hFF);   // period rounds to zero
    add_reg_write(1'b0, fmt_pkg::REG_PRESET_TWO, 8'h00);   // longest period
    add_reg_write(1'b0, fmt_pkg::REG_TIMER_CTRL, 8'h03);
    add_op(fmt_pkg::FUNC_STATUS, 2'd1, 8'h00, 1'b0);
    repeat (3) add_op(fmt_pkg::FUNC_TICK, 2'd2, 8'hA5, 1'b0);
    add_reg_write(1'b0, fmt_pkg::REG_TIMER_CTRL, CTRL_RESET);
    add_reg_write(1'b0, fmt_pkg::REG_TIMER_CTRL, 8'h63);   // both masked
    add_op(fmt_pkg::FUNC_STATUS, 2'd0, 8'h00, 1'b0);
    add_op(fmt_pkg::FUNC_POP, 2'd1, 8'h5A, 1'b1);
    add_op(fmt_pkg::FUNC_POP, 2'd2, 8'hFF, 1'b0);

    queue_random_ops(500);

    // burst: a long run of captured data writes, then pops
    add_reg_write(1'b1, SCRATCH_REG, 8'($urandom));
    for (int k = 0; k < BURST_WRITES; k++) begin
      if (k % 64 == 63) add_op(fmt_pkg::FUNC_TICK, 2'($urandom), 8'($urandom), 1'b0);
      add_op(fmt_pkg::FUNC_WRITE, {1'($urandom), 1'b1}, 8'($urandom), 1'b0);
    end
    repeat (8) add_op(fmt_pkg::FUNC_POP, 2'($urandom), 8'($urandom), 1'b0);

    // sender waits for the block to drain before continuing
    add_op(fmt_pkg::FUNC_STATUS, 2'($urandom), 8'($urandom), 1'b1);
    queue_random_ops(460);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (host_ops.size() != 0 || push) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (awaited_replies.size() != 0)
      report_mismatch("replies never seen", awaited_replies.size(), 0);

    $display("run: %0d beats sent, %0d replies scored, %0d ring entries popped",
             ops_sent, replies_seen, entries_popped);
    $display("run: timers, both banks, write bursts and stalls, %0d lost, %0d mismatches",
             lost_seen, mismatches);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

FILE: sim.f
design/fmt_pkg.sv
design/fmt_fifo.sv
design/fmt_front.sv
design/fmt_back.sv
design/fm_port_timer_status_capture.sv
dv/testbench.sv
